// File: rtl/core/nearest_first_order_scheduler_assert.svh
// Assertion macros shared by the nearest-first order scheduler RTL.
// Included by the top level; depends on signals named clock and reset in scope.
`ifndef NEAREST_FIRST_ORDER_SCHEDULER_ASSERT_SVH
`define NEAREST_FIRST_ORDER_SCHEDULER_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define FNOS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define FNOS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/core/fnos_pkg.sv
// Types, constants and helper functions for the nearest-first order scheduler.
// No dependencies; imported by every module of the block except fnos_ram.
package fnos_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int COORD_BITS  = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int DIFF_W      = COORD_BITS + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int DIST_W      = SQ_W + 2;

   localparam logic [1:0] KIND_POS  = 2'd0;
   localparam logic [1:0] KIND_ADD  = 2'd1;
   localparam logic [1:0] KIND_DISP = 2'd2;

   localparam logic [1:0] OP_POS  = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_DISP = 2'd2;

   localparam logic ST_DISPATCH = 1'b0;
   localparam logic ST_DROPPED  = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [31:0]        stamp;
      logic [15:0]        order_tag;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [15:0]        out_tag;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
   } rsp_type;

   typedef struct packed {
      logic [15:0] tag;
      coord_type   x;
      coord_type   y;
      coord_type   z;
   } entry_type;

   typedef struct packed {
      logic [1:0]  op;
      entry_type   ent;
      logic [31:0] stamp;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             table_full;
   } back_status_type;

   // Sign-extend a 16-bit coordinate, then wrap it to the internal width.
   function automatic coord_type fit_coord(input logic signed [15:0] v);
      logic [31:0] w;
      w = {{16{v[15]}}, v};
      return w[COORD_BITS-1:0];
   endfunction

   function automatic logic [15:0] out_coord(input coord_type c);
      logic [31:0] w;
      w = 32'(c);
      return w[15:0];
   endfunction

   function automatic rsp_type make_rsp(input logic st, input entry_type e);
      rsp_type r;
      r.status  = st;
      r.out_tag = e.tag;
      r.out_x   = out_coord(e.x);
      r.out_y   = out_coord(e.y);
      r.out_z   = out_coord(e.z);
      return r;
   endfunction

endpackage

// File: rtl/core/fnos_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fnos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fnos_front.sv
// Front end: accepts request words, classifies them and queues commands.
// Depends on fnos_pkg.
module fnos_front import fnos_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_word,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       accept;
   logic       keep;
   cmd_type    cmd_new;

   assign req_full = (fill_ff == 2'd2);
   assign accept   = req_push && !req_full;

   always_comb begin
      cmd_new.op        = OP_POS;
      cmd_new.ent.tag   = req_word.order_tag;
      cmd_new.ent.x     = fit_coord(req_word.pos_x);
      cmd_new.ent.y     = fit_coord(req_word.pos_y);
      cmd_new.ent.z     = fit_coord(req_word.pos_z);
      cmd_new.stamp     = req_word.stamp;
      keep              = 1'b1;
      unique case (req_word.kind)
         KIND_POS:  cmd_new.op = OP_POS;
         KIND_ADD:  cmd_new.op = OP_ADD;
         KIND_DISP: cmd_new.op = OP_DISP;
         // The unused kind is taken off the channel and has no effect.
         default:   keep = 1'b0;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept && keep) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_pop && cmd_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      fill_in = fill_ff + 2'(accept && keep) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/core/fnos_back.sv
// Back end: keeps the origin and the order table, and carries out commands.
// Depends on fnos_pkg and fnos_ram.
module fnos_back import fnos_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            cmd_pop,
   output logic            res_valid,
   output rsp_type         res_word,
   input  logic            res_ready,
   output back_status_type stat
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_RESULT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   coord_type        origin_x_ff, origin_x_in;
   coord_type        origin_y_ff, origin_y_in;
   coord_type        origin_z_ff, origin_z_in;
   logic [31:0]      saved_stamp_ff, saved_stamp_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   rsp_type          res_ff, res_in;

   logic              v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]  idx1_ff, idx2_ff, idx3_ff;
   entry_type         ent2_ff, ent3_ff;
   logic [DIFF_W-1:0] dx2_ff, dy2_ff, dz2_ff;
   logic [SQ_W-1:0]   sqx3_ff, sqy3_ff, sqz3_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   entry_type         best_ent_ff;

   logic              ram_we, ram_re;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   entry_type         ram_wdata;
   logic [$bits(entry_type)-1:0] ram_rdata;
   entry_type         rd_ent;
   logic [DIST_W-1:0] sum3;
   logic              take_new;
   logic [IDX_W-1:0]  new_best_idx;
   logic              more_reads;

   function automatic logic [DIFF_W-1:0] abs_diff(input coord_type a, input coord_type b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   fnos_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_ent     = ram_rdata;
   assign sum3       = DIST_W'(sqx3_ff) + DIST_W'(sqy3_ff) + DIST_W'(sqz3_ff);
   assign take_new   = v3_ff && ((idx3_ff == '0) || (sum3 < best_d_ff));
   assign new_best_idx = take_new ? idx3_ff : best_idx_ff;
   assign more_reads = (rd_ptr_ff < count_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      origin_z_in    = origin_z_ff;
      saved_stamp_in = saved_stamp_ff;
      rd_ptr_in      = rd_ptr_ff;
      res_in         = res_ff;
      cmd_pop        = 1'b0;
      res_valid      = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = count_ff[IDX_W-1:0];
      ram_wdata      = cmd.ent;
      ram_re         = 1'b0;
      ram_raddr      = rd_ptr_ff[IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_POS: begin
                     if (cmd.stamp > saved_stamp_ff) begin
                        saved_stamp_in = cmd.stamp;
                        origin_x_in    = cmd.ent.x;
                        origin_y_in    = cmd.ent.y;
                        origin_z_in    = cmd.ent.z;
                     end
                  end
                  OP_ADD: begin
                     saved_stamp_in = '0;
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        res_in   = make_rsp(ST_DROPPED, cmd.ent);
                        state_in = S_RESULT;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_DISP: begin
                     saved_stamp_in = '0;
                     if (count_ff != '0) begin
                        rd_ptr_in = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (more_reads) begin
               ram_re    = 1'b1;
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            if (v3_ff && (CNT_W'(idx3_ff) == count_ff - CNT_W'(1))) begin
               rd_ptr_in = CNT_W'(new_best_idx) + CNT_W'(1);
               state_in  = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // Reads run one entry ahead of the writes that close the gap.
            if (more_reads) begin
               ram_re    = 1'b1;
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            if (v1_ff) begin
               ram_we    = 1'b1;
               ram_waddr = idx1_ff - IDX_W'(1);
               ram_wdata = rd_ent;
            end
            if (!more_reads && !v1_ff) begin
               count_in = count_ff - CNT_W'(1);
               res_in   = make_rsp(ST_DISPATCH, best_ent_ff);
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         saved_stamp_ff <= '0;
         rd_ptr_ff      <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         origin_z_ff    <= origin_z_in;
         saved_stamp_ff <= saved_stamp_in;
         rd_ptr_ff      <= rd_ptr_in;
         v1_ff          <= ram_re;
         v2_ff          <= v1_ff && (state_ff == S_SCAN);
         v3_ff          <= v2_ff && (state_ff == S_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      idx1_ff <= ram_raddr;
      idx2_ff <= idx1_ff;
      ent2_ff <= rd_ent;
      dx2_ff  <= abs_diff(rd_ent.x, origin_x_ff);
      dy2_ff  <= abs_diff(rd_ent.y, origin_y_ff);
      dz2_ff  <= abs_diff(rd_ent.z, origin_z_ff);
      idx3_ff <= idx2_ff;
      ent3_ff <= ent2_ff;
      sqx3_ff <= dx2_ff * dx2_ff;
      sqy3_ff <= dy2_ff * dy2_ff;
      sqz3_ff <= dz2_ff * dz2_ff;
      if (take_new && (state_ff == S_SCAN)) begin
         best_d_ff   <= sum3;
         best_idx_ff <= idx3_ff;
         best_ent_ff <= ent3_ff;
      end
   end

   assign res_word        = res_ff;
   assign stat.count      = count_ff;
   assign stat.table_full = (count_ff == CNT_W'(TABLE_DEPTH));

endmodule

// File: rtl/core/fnos_rsp_queue.sv
// Two-word result queue between the back end and the result channel.
// Depends on fnos_pkg.
module fnos_rsp_queue import fnos_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   input  rsp_type res_word,
   output logic    res_ready,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   assign res_ready = (fill_ff != 2'd2);
   assign rsp_empty = (fill_ff == 2'd0);
   assign push      = res_valid && res_ready;
   assign pop       = rsp_pop && !rsp_empty;
   assign fill_in   = fill_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ push;
         rd_ptr_ff <= rd_ptr_ff ^ pop;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= res_word;
      end
   end

   assign rsp_word = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/core/nearest_first_order_scheduler.sv
// Nearest-first order scheduler: table of pending orders served by distance.
// Depends on fnos_pkg, fnos_front, fnos_back, fnos_rsp_queue and the assert header.
//
// Request words enter through req_push/req_full: a position update moves the
// reference point when its stamp beats the saved stamp, an add appends an
// order, a dispatch removes the order nearest the reference point (oldest on
// a tie). Result words leave through rsp_empty/rsp_pop: a dispatched order, or
// an add dropped because the table was full. The unused kind is discarded.
// A two-word command queue sits between the front end and the execution
// engine, and a two-word result queue sits in front of the result channel,
// so requests keep being taken while a result waits to be popped.
// A dispatch scans the table through the RAM read port and the distance
// pipeline, then closes the gap at the chosen slot k by moving each later
// entry down one slot, then posts the result. A stalled result channel stops
// the engine only once the result queue is full. Reset empties the table and
// both queues and clears the reference point and the saved stamp.
module nearest_first_order_scheduler import fnos_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_word,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);

`include "nearest_first_order_scheduler_assert.svh"

   logic            cmd_valid;
   cmd_type         cmd;
   logic            cmd_pop;
   logic            res_valid;
   rsp_type         res_word;
   logic            res_ready;
   back_status_type back_stat;

   fnos_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   fnos_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .res_valid (res_valid),
      .res_word  (res_word),
      .res_ready (res_ready),
      .stat      (back_stat)
   );

   fnos_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_word  (res_word),
      .res_ready (res_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   `FNOS_ASSERT(a_count_bound, back_stat.count <= CNT_W'(TABLE_DEPTH), "order count overflow")
   `FNOS_ASSERT(a_drop_when_full, res_valid && res_ready && res_word.status == ST_DROPPED |-> back_stat.table_full, "drop reported with room left")
   `FNOS_ASSERT(a_rsp_kept, !rsp_empty && !rsp_pop |=> !rsp_empty, "waiting result lost")
   `FNOS_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> rsp_empty, "result queue not empty after reset")

endmodule
